[hdl/rclfp_pkg.sv]
// shared types, constants and register codes of the rc link frame parser
package rclfp_pkg;

    localparam int STORED_PAYLOAD_BYTES = 22;
    localparam int NUM_CHANNELS         = 16;
    localparam int CHANNEL_BITS         = 11;

    localparam logic [7:0] SYNC_BYTE      = 8'hC8;
    localparam logic [7:0] CRC_POLY       = 8'hD5;
    localparam logic [7:0] TYPE_CHANNELS  = 8'h16;
    localparam logic [7:0] TYPE_LINKSTATS = 8'h14;
    localparam logic [7:0] MIN_LENGTH     = 8'd2;

    localparam int LQ_BYTE = 2;
    localparam int RF_BYTE = 5;

    localparam logic [3:0] AUX_FIRST_CHANNEL = 4'd4;

    localparam logic [10:0] AUX_THRESHOLD_RESET = 11'd1100;
    localparam logic [6:0]  MAX_LENGTH_RESET    = 7'd64;
    localparam logic [7:0]  READY_FRAMES_RESET  = 8'd131;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_ADDR_W-1:0] CFG_AUX_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_LENGTH    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_READY_FRAMES  = 2'd2;

    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [2:0] {
        KIND_CHANNEL   = 3'd0,
        KIND_LINKSTATS = 3'd1,
        KIND_OTHER     = 3'd2,
        KIND_HDR_ERR   = 3'd3,
        KIND_CRC_ERR   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_TYPE,
        PH_PAYLOAD,
        PH_CRC
    } t_phase;

    typedef struct packed {
        logic [10:0] aux_threshold;
        logic [6:0]  max_length;
        logic [7:0]  ready_frames;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  frame_type;
        logic [7:0]  rf_mode;
        logic [7:0]  link_quality;
        logic        link_ready;
    } t_job;

endpackage

[hdl/rc_link_frame_parser.sv]
// top level of the rc link frame parser: config registers, parser, result sequencer
//
// channel   direction  contents
// s_axis    in         rx_byte, one link byte per item
// m_axis    out        frame results; tuser kind, tlast on final item of a job
// cfg       in         write-only registers: aux_threshold, max_length, ready_frames
//
// a link byte is taken whenever s_axis_tready is high and the next byte may follow in the next cycle
// a byte that ends a frame or fails the length check starts a job in the sequencer;
// the job issues one item per cycle while the output register can load: 16 for an rc-channels frame, else 1
// input stalls only while a job still holds items not yet in the output register
// synchronous active-low reset; payload store cleared by reset
module rc_link_frame_parser #(
    parameter int STORED_PAYLOAD_BYTES = rclfp_pkg::STORED_PAYLOAD_BYTES,
    parameter int NUM_CHANNELS         = rclfp_pkg::NUM_CHANNELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [7:0] rx_byte
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] frame_type, [11:8] channel_index, [22:12] channel_value, [23] aux_high,
    // [31:24] rf_mode, [39:32] link_quality, [40] link_ready, rest zero
    output logic [rclfp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [rclfp_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // [2:0] kind
    output logic                                 m_axis_tlast,
    input  logic                                 i_cfg_we,
    input  logic [rclfp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rclfp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int SNAP_BITS = NUM_CHANNELS * rclfp_pkg::CHANNEL_BITS;

    rclfp_pkg::t_cfg      r_cfg;
    logic                 accept;
    logic                 job_valid;
    rclfp_pkg::t_job      job;
    logic [SNAP_BITS-1:0] snap;
    logic                 free;

    rclfp_pkg::t_kind     out_kind;
    logic [7:0]           out_frame_type;
    logic [3:0]           out_channel_index;
    logic [10:0]          out_channel_value;
    logic                 out_aux_high;
    logic [7:0]           out_rf_mode;
    logic [7:0]           out_link_quality;
    logic                 out_link_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.aux_threshold <= rclfp_pkg::AUX_THRESHOLD_RESET;
            r_cfg.max_length    <= rclfp_pkg::MAX_LENGTH_RESET;
            r_cfg.ready_frames  <= rclfp_pkg::READY_FRAMES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rclfp_pkg::CFG_AUX_THRESHOLD: r_cfg.aux_threshold <= i_cfg_wdata;
                rclfp_pkg::CFG_MAX_LENGTH:    r_cfg.max_length    <= i_cfg_wdata[6:0];
                rclfp_pkg::CFG_READY_FRAMES:  r_cfg.ready_frames  <= i_cfg_wdata[7:0];
                default:                      r_cfg               <= r_cfg;
            endcase
        end
    end

    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && free;

    rclfp_parser #(
        .STORED_PAYLOAD_BYTES (STORED_PAYLOAD_BYTES),
        .NUM_CHANNELS         (NUM_CHANNELS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (s_axis_tdata),
        .i_cfg       (r_cfg),
        .o_job_valid (job_valid),
        .o_job       (job),
        .o_snap      (snap)
    );

    rclfp_emitter #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .i_snap          (snap),
        .i_aux_threshold (r_cfg.aux_threshold),
        .o_free          (free),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_kind          (out_kind),
        .o_frame_type    (out_frame_type),
        .o_channel_index (out_channel_index),
        .o_channel_value (out_channel_value),
        .o_aux_high      (out_aux_high),
        .o_rf_mode       (out_rf_mode),
        .o_link_quality  (out_link_quality),
        .o_link_ready    (out_link_ready),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {7'b0, out_link_ready, out_link_quality, out_rf_mode,
                           out_aux_high, out_channel_value, out_channel_index,
                           out_frame_type};

endmodule

[hdl/rclfp_parser.sv]
// byte parser: sync hunt, length check, payload store, crc and good-frame counter
module rclfp_parser #(
    parameter int STORED_PAYLOAD_BYTES = rclfp_pkg::STORED_PAYLOAD_BYTES,
    parameter int NUM_CHANNELS         = rclfp_pkg::NUM_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  rclfp_pkg::t_cfg       i_cfg,
    output logic                  o_job_valid,
    output rclfp_pkg::t_job       o_job,
    output logic [NUM_CHANNELS*rclfp_pkg::CHANNEL_BITS-1:0] o_snap
);

    localparam int STORE_BITS = STORED_PAYLOAD_BYTES * 8;
    localparam int SNAP_BITS  = NUM_CHANNELS * rclfp_pkg::CHANNEL_BITS;
    localparam int IDX_W      = $clog2(STORED_PAYLOAD_BYTES);

    rclfp_pkg::t_phase r_phase, n_phase;
    logic [6:0] r_frame_len;
    logic [6:0] r_byte_count;
    logic [7:0] r_crc;
    logic [7:0] r_type;
    logic [7:0] r_store [STORED_PAYLOAD_BYTES];
    logic [7:0] r_good_count;
    logic       r_ready;

    logic       len_bad;
    logic [6:0] count_inc;
    logic [7:0] crc_in;
    logic [7:0] crc_next;
    logic       crc_bad;
    logic [7:0] count_sat;
    logic       count_over;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ rclfp_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    assign len_bad    = (i_rx_byte < rclfp_pkg::MIN_LENGTH)
                     || (i_rx_byte > {1'b0, i_cfg.max_length});
    assign count_inc  = r_byte_count + 7'd1;
    assign crc_in     = (r_phase == rclfp_pkg::PH_TYPE) ? 8'h00 : r_crc;
    assign crc_next   = crc_step(crc_in, i_rx_byte);
    assign crc_bad    = (i_rx_byte != r_crc);
    assign count_sat  = (r_good_count == 8'hFF) ? r_good_count : r_good_count + 8'd1;
    assign count_over = (count_sat > i_cfg.ready_frames);

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            rclfp_pkg::PH_HUNT: begin
                if (i_rx_byte == rclfp_pkg::SYNC_BYTE) n_phase = rclfp_pkg::PH_LEN;
            end
            rclfp_pkg::PH_LEN: begin
                n_phase = len_bad ? rclfp_pkg::PH_HUNT : rclfp_pkg::PH_TYPE;
            end
            rclfp_pkg::PH_TYPE: begin
                n_phase = (r_frame_len > 7'd2) ? rclfp_pkg::PH_PAYLOAD : rclfp_pkg::PH_CRC;
            end
            rclfp_pkg::PH_PAYLOAD: begin
                if (count_inc >= r_frame_len - 7'd2) n_phase = rclfp_pkg::PH_CRC;
            end
            default: n_phase = rclfp_pkg::PH_HUNT;
        endcase
    end

    // result job raised by the byte being accepted
    always_comb begin
        o_job_valid        = 1'b0;
        o_job.kind         = rclfp_pkg::KIND_HDR_ERR;
        o_job.frame_type   = 8'h00;
        o_job.rf_mode      = 8'h00;
        o_job.link_quality = 8'h00;
        o_job.link_ready   = r_ready;
        case (r_phase)
            rclfp_pkg::PH_LEN: begin
                o_job_valid = i_accept && len_bad;
            end
            rclfp_pkg::PH_CRC: begin
                o_job_valid      = i_accept;
                o_job.frame_type = r_type;
                if (crc_bad) begin
                    o_job.kind = rclfp_pkg::KIND_CRC_ERR;
                end else begin
                    o_job.link_ready = r_ready | count_over;
                    if (r_type == rclfp_pkg::TYPE_CHANNELS) begin
                        o_job.kind = rclfp_pkg::KIND_CHANNEL;
                    end else if (r_type == rclfp_pkg::TYPE_LINKSTATS) begin
                        o_job.kind         = rclfp_pkg::KIND_LINKSTATS;
                        o_job.rf_mode      = r_store[rclfp_pkg::RF_BYTE];
                        o_job.link_quality = r_store[rclfp_pkg::LQ_BYTE];
                    end else begin
                        o_job.kind = rclfp_pkg::KIND_OTHER;
                    end
                end
            end
            default: o_job_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= rclfp_pkg::PH_HUNT;
            r_frame_len  <= '0;
            r_byte_count <= '0;
            r_crc        <= '0;
            r_type       <= '0;
            r_good_count <= '0;
            r_ready      <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            case (r_phase)
                rclfp_pkg::PH_LEN: begin
                    if (!len_bad) begin
                        r_frame_len  <= i_rx_byte[6:0];
                        r_byte_count <= '0;
                        r_crc        <= '0;
                    end
                end
                rclfp_pkg::PH_TYPE: begin
                    r_type       <= i_rx_byte;
                    r_crc        <= crc_next;
                    r_byte_count <= '0;
                end
                rclfp_pkg::PH_PAYLOAD: begin
                    r_crc        <= crc_next;
                    r_byte_count <= count_inc;
                end
                rclfp_pkg::PH_CRC: begin
                    if (!crc_bad) begin
                        if (count_over) begin
                            r_ready      <= 1'b1;
                            r_good_count <= i_cfg.ready_frames;
                        end else begin
                            r_good_count <= count_sat;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload bytes beyond the store only feed the crc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORED_PAYLOAD_BYTES; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_accept && r_phase == rclfp_pkg::PH_PAYLOAD
                     && r_byte_count < 7'(STORED_PAYLOAD_BYTES)) begin
            r_store[r_byte_count[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    // channel bit field as seen at the crc byte, zero beyond the store
    for (genvar g = 0; g < SNAP_BITS; g++) begin : g_snap
        if (g < STORE_BITS) begin : g_in
            assign o_snap[g] = r_store[g / 8][g % 8];
        end else begin : g_out
            assign o_snap[g] = 1'b0;
        end
    end

endmodule

[hdl/rclfp_emitter.sv]
// result sequencer: holds one frame job and issues its items into the output register
module rclfp_emitter #(
    parameter int NUM_CHANNELS = rclfp_pkg::NUM_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  rclfp_pkg::t_job       i_job,
    input  logic [NUM_CHANNELS*rclfp_pkg::CHANNEL_BITS-1:0] i_snap,
    input  logic [10:0]           i_aux_threshold,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output rclfp_pkg::t_kind      o_kind,
    output logic [7:0]            o_frame_type,
    output logic [3:0]            o_channel_index,
    output logic [10:0]           o_channel_value,
    output logic                  o_aux_high,
    output logic [7:0]            o_rf_mode,
    output logic [7:0]            o_link_quality,
    output logic                  o_link_ready,
    output logic                  o_last
);

    localparam int SNAP_BITS = NUM_CHANNELS * rclfp_pkg::CHANNEL_BITS;
    localparam int IW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                 r_job_valid;
    rclfp_pkg::t_job      r_job;
    logic [SNAP_BITS-1:0] r_snap;
    logic [IW-1:0]        r_idx;

    logic                 r_out_valid;
    rclfp_pkg::t_kind     r_kind;
    logic [7:0]           r_frame_type;
    logic [3:0]           r_channel_index;
    logic [10:0]          r_channel_value;
    logic                 r_aux_high;
    logic [7:0]           r_rf_mode;
    logic [7:0]           r_link_quality;
    logic                 r_link_ready;
    logic                 r_last;

    logic        out_load;
    logic        is_chan;
    logic [10:0] cur_value;
    logic [3:0]  cur_idx;
    logic        cur_aux;
    logic        cur_last;
    logic        issue;

    assign out_load  = !r_out_valid || i_ready;
    assign is_chan   = (r_job.kind == rclfp_pkg::KIND_CHANNEL);
    assign cur_value = r_snap[rclfp_pkg::CHANNEL_BITS-1:0];
    assign cur_idx   = 4'(r_idx);
    assign cur_aux   = is_chan && (cur_idx >= rclfp_pkg::AUX_FIRST_CHANNEL)
                    && (cur_value > i_aux_threshold);
    assign cur_last  = !is_chan || (r_idx == IW'(NUM_CHANNELS - 1));
    assign issue     = r_job_valid && out_load;
    assign o_free    = !r_job_valid || (issue && cur_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (i_job_valid) begin
            r_job_valid <= 1'b1;
            r_idx       <= '0;
        end else if (issue) begin
            if (cur_last) begin
                r_job_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    // channel field shifts down one channel per item
    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_job  <= i_job;
            r_snap <= i_snap;
        end else if (issue) begin
            r_snap <= r_snap >> rclfp_pkg::CHANNEL_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_kind          <= r_job.kind;
            r_frame_type    <= r_job.frame_type;
            r_channel_index <= is_chan ? cur_idx : 4'd0;
            r_channel_value <= is_chan ? cur_value : 11'd0;
            r_aux_high      <= cur_aux;
            r_rf_mode       <= r_job.rf_mode;
            r_link_quality  <= r_job.link_quality;
            r_link_ready    <= r_job.link_ready;
            r_last          <= cur_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_frame_type    = r_frame_type;
    assign o_channel_index = r_channel_index;
    assign o_channel_value = r_channel_value;
    assign o_aux_high      = r_aux_high;
    assign o_rf_mode       = r_rf_mode;
    assign o_link_quality  = r_link_quality;
    assign o_link_ready    = r_link_ready;
    assign o_last          = r_last;

endmodule
